// ===== sv/fram_pkg.sv =====
`timescale 1ns / 1ps

package fram_pkg;

	// Data word, register index and opcode widths.
	localparam int WORD_W       = 64;
	localparam int IDX_W        = 2;
	localparam int KIND_W       = 4;
	localparam int NUM_REGS_DEF = 4;
	localparam int CNT_W        = $clog2(WORD_W);

	// Instruction opcodes.
	typedef enum logic [KIND_W-1:0] {
		K_IN   = 4'd0,
		K_OUT  = 4'd1,
		K_MOV  = 4'd2,
		K_XCHG = 4'd3,
		K_ADD  = 4'd4,
		K_SUB  = 4'd5,
		K_MUL  = 4'd6,
		K_DIV  = 4'd7,
		K_MOD  = 4'd8,
		K_AND  = 4'd9,
		K_OR   = 4'd10,
		K_XOR  = 4'd11
	} kind_t;

	// Which latched register index drives the file read address.
	typedef enum logic [1:0] {
		RSEL_DEST,
		RSEL_SRC1,
		RSEL_SRC2
	} rsel_t;

	// Source of the register file write data.
	typedef enum logic [1:0] {
		WSRC_IMM,
		WSRC_OPA,
		WSRC_OPB,
		WSRC_ALU
	} wsrc_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  load;
		rsel_t rsel;
		logic  cap_a;
		logic  cap_b;
		logic  we;
		logic  wr_src1;
		wsrc_t wsrc;
		kind_t op;
		logic  init;
		logic  step;
		logic  emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic b_zero;
		logic out_busy;
	} sts_t;

endpackage

// ===== sv/fram_ctrl.sv =====
`timescale 1ns / 1ps

module fram_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [fram_pkg::KIND_W-1:0]     kind,
	input  logic                            three_operand,
	input  fram_pkg::sts_t                  sts,
	output logic                            in_stall,
	output fram_pkg::cmd_t                  cmd
);
	import fram_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_CAP_B,
		S_EXEC,
		S_ITER,
		S_WB,
		S_WB2,
		S_EMIT
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	state_t           state_q;
	kind_t            kind_q;
	logic             three_q;
	logic [CNT_W-1:0] cnt_q;
	kind_t            kind_in;

	assign kind_in  = kind_t'(kind);
	assign in_stall = (state_q != S_IDLE);

	// Sequencer: one instruction at a time, operands read one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_IN;
			three_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind_in;
						three_q <= three_operand;
						unique case (kind_in) inside
							K_IN: state_q <= S_WB;
							K_OUT, K_MOV, K_XCHG, K_ADD, K_SUB, K_MUL, K_DIV,
							K_MOD, K_AND, K_OR, K_XOR: state_q <= S_RD_A;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					unique case (kind_q) inside
						K_OUT:   state_q <= S_EMIT;
						K_MOV:   state_q <= S_WB;
						default: state_q <= S_CAP_B;
					endcase
				end
				S_CAP_B: state_q <= (kind_q == K_XCHG) ? S_WB : S_EXEC;
				S_EXEC: begin
					cnt_q <= '0;
					unique case (kind_q) inside
						K_MUL:        state_q <= S_ITER;
						K_DIV, K_MOD: state_q <= sts.b_zero ? S_IDLE : S_ITER;
						default:      state_q <= S_IDLE;
					endcase
				end
				S_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= S_WB;
					end
				end
				S_WB:  state_q <= (kind_q == K_XCHG) ? S_WB2 : S_IDLE;
				S_WB2: state_q <= S_IDLE;
				S_EMIT: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode from the current state and the latched opcode.
	always_comb begin
		cmd         = '0;
		cmd.rsel    = RSEL_DEST;
		cmd.wsrc    = WSRC_ALU;
		cmd.op      = kind_q;
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.cap_a   = (state_q == S_RD_B);
		cmd.cap_b   = (state_q == S_CAP_B);
		cmd.init    = (state_q == S_EXEC);
		cmd.step    = (state_q == S_ITER);
		cmd.emit    = (state_q == S_EMIT) && !sts.out_busy;
		cmd.wr_src1 = (state_q == S_WB2);

		unique case (state_q)
			S_RD_A: begin
				unique case (kind_q) inside
					K_OUT, K_XCHG: cmd.rsel = RSEL_DEST;
					K_MOV:         cmd.rsel = RSEL_SRC1;
					default:       cmd.rsel = three_q ? RSEL_SRC1 : RSEL_DEST;
				endcase
			end
			S_RD_B: begin
				if (kind_q == K_XCHG) begin
					cmd.rsel = RSEL_SRC1;
				end else begin
					cmd.rsel = three_q ? RSEL_SRC2 : RSEL_SRC1;
				end
			end
			S_EXEC: begin
				unique case (kind_q) inside
					K_ADD, K_SUB, K_AND, K_OR, K_XOR: cmd.we = 1'b1;
					default:                          cmd.we = 1'b0;
				endcase
			end
			S_WB: begin
				cmd.we = 1'b1;
				unique case (kind_q) inside
					K_IN:    cmd.wsrc = WSRC_IMM;
					K_MOV:   cmd.wsrc = WSRC_OPA;
					K_XCHG:  cmd.wsrc = WSRC_OPB;
					default: cmd.wsrc = WSRC_ALU;
				endcase
			end
			S_WB2: begin
				cmd.we   = 1'b1;
				cmd.wsrc = WSRC_OPA;
			end
			default: begin
				cmd.we = 1'b0;
			end
		endcase
	end

	// A result is only loaded into the output register when it is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("result loaded while output register still held");

	// The last shift step always hands over to the write-back.
	a_iter_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && cnt_q == CNT_LAST) |=> (state_q == S_WB))
		else $error("iteration did not end in write-back");

	// An iteration never starts without a multiply, divide or modulo.
	a_iter_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER) |-> (kind_q == K_MUL || kind_q == K_DIV || kind_q == K_MOD))
		else $error("iteration for a single-cycle operation");

endmodule

// ===== sv/fram_dp.sv =====
`timescale 1ns / 1ps

module fram_dp #(
	parameter int NUM_REGS = fram_pkg::NUM_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fram_pkg::cmd_t                     cmd,
	input  logic [fram_pkg::IDX_W-1:0]         dest_reg,
	input  logic [fram_pkg::IDX_W-1:0]         first_src,
	input  logic [fram_pkg::IDX_W-1:0]         second_src,
	input  logic signed [fram_pkg::WORD_W-1:0] immediate,
	input  logic                               out_stall,
	output fram_pkg::sts_t                     sts,
	output logic                               out_valid,
	output logic signed [fram_pkg::WORD_W-1:0] out_value
);
	import fram_pkg::*;

	// Only the addressable part of the file is built.
	localparam int FILE_DEPTH = (NUM_REGS < (1 << IDX_W)) ? NUM_REGS : (1 << IDX_W);
	localparam int AW         = $clog2(FILE_DEPTH);

	logic [IDX_W-1:0]  dest_q, src1_q, src2_q;
	logic [WORD_W-1:0] imm_q;
	logic [IDX_W-1:0]  raddr, waddr;
	logic              rd_in, wr_ok;
	logic [WORD_W-1:0] rf_mem [FILE_DEPTH];
	logic [FILE_DEPTH-1:0] rf_vld_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_hit_q;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] op_a_q, op_b_q;
	logic [WORD_W-1:0] acc_q, sh_q, aux_q;
	logic [WORD_W-1:0] mag_a, mag_b;
	logic [WORD_W:0]   div_shift;
	logic [WORD_W+1:0] div_diff;
	logic [WORD_W-1:0] alu_res, wdata;
	logic [WORD_W-1:0] out_value_q;
	logic              out_valid_q;

	// Instruction fields are latched on the accepted beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dest_q <= dest_reg;
			src1_q <= first_src;
			src2_q <= second_src;
			imm_q  <= immediate;
		end
	end

	// Read and write address selection, with the range check on each.
	always_comb begin
		unique case (cmd.rsel)
			RSEL_SRC1: raddr = src1_q;
			RSEL_SRC2: raddr = src2_q;
			default:   raddr = dest_q;
		endcase
	end
	assign waddr = cmd.wr_src1 ? src1_q : dest_q;
	assign rd_in = ({{(32-IDX_W){1'b0}}, raddr} < 32'(FILE_DEPTH));
	assign wr_ok = cmd.we && ({{(32-IDX_W){1'b0}}, waddr} < 32'(FILE_DEPTH));

	// Register file: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			rf_mem[waddr[AW-1:0]] <= wdata;
		end
		rd_data_q <= rf_mem[raddr[AW-1:0]];
	end

	// Per-entry valid bits stand in for the reset clear of the file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				rf_vld_q[waddr[AW-1:0]] <= 1'b1;
			end
			rd_hit_q <= rd_in && rf_vld_q[raddr[AW-1:0]];
		end
	end
	assign rd_word = rd_hit_q ? rd_data_q : '0;

	// Operand capture.
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			op_a_q <= rd_word;
		end
		if (cmd.cap_b) begin
			op_b_q <= rd_word;
		end
	end

	assign mag_a     = op_a_q[WORD_W-1] ? (~op_a_q + 1'b1) : op_a_q;
	assign mag_b     = op_b_q[WORD_W-1] ? (~op_b_q + 1'b1) : op_b_q;
	assign div_shift = {acc_q, sh_q[WORD_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, aux_q};

	// Shared shift unit: shift-add multiply or restoring divide, one bit a cycle.
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			acc_q <= '0;
			if (cmd.op == K_MUL) begin
				sh_q  <= op_b_q;
				aux_q <= op_a_q;
			end else begin
				sh_q  <= mag_a;
				aux_q <= mag_b;
			end
		end else if (cmd.step) begin
			if (cmd.op == K_MUL) begin
				if (sh_q[0]) begin
					acc_q <= acc_q + aux_q;
				end
				sh_q  <= sh_q >> 1;
				aux_q <= aux_q << 1;
			end else if (!div_diff[WORD_W+1]) begin
				acc_q <= div_diff[WORD_W-1:0];
				sh_q  <= {sh_q[WORD_W-2:0], 1'b1};
			end else begin
				acc_q <= div_shift[WORD_W-1:0];
				sh_q  <= {sh_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	// Result select, with the sign fix of quotient and remainder.
	always_comb begin
		unique case (cmd.op)
			K_ADD: alu_res = op_a_q + op_b_q;
			K_SUB: alu_res = op_a_q - op_b_q;
			K_MUL: alu_res = acc_q;
			K_DIV: alu_res = (op_a_q[WORD_W-1] ^ op_b_q[WORD_W-1]) ? (~sh_q + 1'b1) : sh_q;
			K_MOD: alu_res = op_a_q[WORD_W-1] ? (~acc_q + 1'b1) : acc_q;
			K_AND: alu_res = op_a_q & op_b_q;
			K_OR:  alu_res = op_a_q | op_b_q;
			K_XOR: alu_res = op_a_q ^ op_b_q;
			default: alu_res = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wsrc)
			WSRC_IMM: wdata = imm_q;
			WSRC_OPA: wdata = op_a_q;
			WSRC_OPB: wdata = op_b_q;
			default:  wdata = alu_res;
		endcase
	end

	// Output register: holds a beat until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= op_a_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign sts.b_zero   = (op_b_q == '0);
	assign sts.out_busy = out_valid_q && out_stall;

	// A taken beat with nothing new behind it empties the output register.
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !cmd.emit) |=> !out_valid_q)
		else $error("output beat repeated");

endmodule

// ===== sv/four_register_alu_machine_top.sv =====
`timescale 1ns / 1ps
// MUL, DIV and MOD run one bit per cycle in a shared shift unit; a zero divisor ends DIV and MOD without a write.
// Throughput: one instruction at a time; the next beat is taken when the last one ends.
// An OUT result waits in an output register while the next instruction is taken.
// Reset (arst_n low) clears all registers to zero through per-entry valid bits.
module four_register_alu_machine_top #(
	parameter int NUM_REGS = fram_pkg::NUM_REGS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [fram_pkg::KIND_W-1:0]        kind,
	input  logic [fram_pkg::IDX_W-1:0]         dest_reg,
	input  logic [fram_pkg::IDX_W-1:0]         first_src,
	input  logic [fram_pkg::IDX_W-1:0]         second_src,
	input  logic                               three_operand,
	input  logic signed [fram_pkg::WORD_W-1:0] immediate,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fram_pkg::WORD_W-1:0] out_value
);
	import fram_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	fram_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.kind          (kind),
		.three_operand (three_operand),
		.sts           (sts),
		.in_stall      (in_stall),
		.cmd           (cmd)
	);

	// Register file, operand registers, shift unit and output register.
	fram_dp #(
		.NUM_REGS (NUM_REGS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dest_reg   (dest_reg),
		.first_src  (first_src),
		.second_src (second_src),
		.immediate  (immediate),
		.out_stall  (out_stall),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_value  (out_value)
	);

endmodule

// ===== tb/four_register_alu_machine_top_test.sv =====
`timescale 1ns / 1ps

module four_register_alu_machine_top_test;
	import fram_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT   = 4000;
	localparam int REPORT_MAX   = 10;

	localparam logic [KIND_W-1:0] KIND_LAST = {KIND_W{1'b1}};
	localparam logic [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

	// One pre-decoded instruction as it is presented on the input channel.
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  dest;
		logic [IDX_W-1:0]  src1;
		logic [IDX_W-1:0]  src2;
		logic              three;
		logic [WORD_W-1:0] imm;
	} instr_t;

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     in_valid      = 1'b0;
	logic                     in_stall;
	logic [KIND_W-1:0]        kind          = '0;
	logic [IDX_W-1:0]         dest_reg      = '0;
	logic [IDX_W-1:0]         first_src     = '0;
	logic [IDX_W-1:0]         second_src    = '0;
	logic                     three_operand = 1'b0;
	logic signed [WORD_W-1:0] immediate     = '0;
	logic                     out_valid;
	logic                     out_stall     = 1'b0;
	logic signed [WORD_W-1:0] out_value;

	// Predicted machine state and the values that OUT beats must produce.
	logic [WORD_W-1:0] arch_regs [NUM_REGS_DEF];
	logic [WORD_W-1:0] out_expected[$];
	instr_t            instr_queue[$];
	instr_t            presented;

	int instr_total  = 0;
	int useful_count = 0;
	int beats_taken  = 0;
	int fail_count   = 0;
	int cycle_count  = 0;
	int idle_cycles  = 0;
	int send_gap     = 0;
	int stall_gap    = 0;
	int hold_left    = 0;
	int holds_done   = 0;
	logic calm;

	four_register_alu_machine_top #(
		.NUM_REGS(NUM_REGS_DEF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.dest_reg     (dest_reg),
		.first_src    (first_src),
		.second_src   (second_src),
		.three_operand(three_operand),
		.immediate    (immediate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_value    (out_value)
	);

	// A quarter of the run goes without random pauses on either side.
	assign calm = (cycle_count[9:8] == 2'd0);

	function automatic logic [WORD_W-1:0] read_reg(logic [IDX_W-1:0] idx);
		if (idx < NUM_REGS_DEF)
			return arch_regs[idx];
		return '0;
	endfunction

	function automatic void write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] v);
		if (idx < NUM_REGS_DEF)
			arch_regs[idx] = v;
	endfunction

	// Applies one accepted instruction to the predicted register file.
	function automatic void execute_instr(instr_t it);
		logic [WORD_W-1:0] a, b, t, ma, mb;
		logic do_write;
		case (it.kind)
			K_IN: write_reg(it.dest, it.imm);
			K_OUT: out_expected.push_back(read_reg(it.dest));
			K_MOV: write_reg(it.dest, read_reg(it.src1));
			K_XCHG: begin
				a = read_reg(it.dest);
				b = read_reg(it.src1);
				write_reg(it.dest, b);
				write_reg(it.src1, a);
			end
			K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_AND, K_OR, K_XOR: begin
				a = it.three ? read_reg(it.src1) : read_reg(it.dest);
				b = it.three ? read_reg(it.src2) : read_reg(it.src1);
				ma = a[WORD_W-1] ? -a : a;
				mb = b[WORD_W-1] ? -b : b;
				do_write = 1'b1;
				t = '0;
				case (it.kind)
					K_ADD: t = a + b;
					K_SUB: t = a - b;
					K_MUL: t = a * b;
					K_DIV: begin
						// Magnitudes keep the most negative word over -1 well defined.
						if (b == '0) begin
							do_write = 1'b0;
						end else begin
							t = ma / mb;
							if (a[WORD_W-1] ^ b[WORD_W-1])
								t = -t;
						end
					end
					K_MOD: begin
						if (b == '0) begin
							do_write = 1'b0;
						end else begin
							t = ma % mb;
							if (a[WORD_W-1])
								t = -t;
						end
					end
					K_AND: t = a & b;
					K_OR: t = a | b;
					default: t = a ^ b;
				endcase
				if (do_write)
					write_reg(it.dest, t);
			end
			default: ;
		endcase
	endfunction

	function automatic instr_t make_instr(logic [KIND_W-1:0] k, logic [IDX_W-1:0] d,
			logic [IDX_W-1:0] s1, logic [IDX_W-1:0] s2, logic three, logic [WORD_W-1:0] imm);
		instr_t it;
		it.kind = k;
		it.dest = d;
		it.src1 = s1;
		it.src2 = s2;
		it.three = three;
		it.imm = imm;
		return it;
	endfunction

	function automatic void queue_instr(instr_t it);
		instr_queue.push_back(it);
		if (it.kind <= K_XOR)
			useful_count++;
	endfunction

	// Operand values: full random words, small values, extremes and powers of two.
	function automatic logic [WORD_W-1:0] rand_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: w = {$urandom, $urandom};
			4, 5, 6: w = longint'(int'($urandom_range(0, 40)) - 20);
			7: begin
				case ($urandom_range(0, 4))
					0: w = WORD_MIN;
					1: w = WORD_MAX;
					2: w = WORD_ONES;
					3: w = '0;
					default: w = 64'd1;
				endcase
			end
			8: begin
				w = 64'd1 << $urandom_range(0, WORD_W - 1);
				if ($urandom_range(0, 1))
					w = -w;
			end
			default: w = 64'($urandom_range(1, 1000));
		endcase
		return w;
	endfunction

	function automatic instr_t rand_instr();
		instr_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 14)
			it.kind = K_IN;
		else if (r < 30)
			it.kind = K_OUT;
		else if (r < 35)
			it.kind = K_MOV;
		else if (r < 40)
			it.kind = K_XCHG;
		else if (r < 97)
			it.kind = KIND_W'($urandom_range(K_ADD, K_XOR));
		else
			it.kind = KIND_W'($urandom_range(K_XOR + 1, KIND_LAST));
		it.dest = IDX_W'($urandom);
		it.src1 = IDX_W'($urandom);
		it.src2 = IDX_W'($urandom);
		it.three = 1'($urandom);
		it.imm = rand_word();
		return it;
	endfunction

	// Loads both sources, runs one ALU operation and reads back its destination.
	function automatic void queue_alu_sequence();
		instr_t op;
		op = rand_instr();
		op.kind = KIND_W'($urandom_range(K_ADD, K_XOR));
		queue_instr(make_instr(K_IN, op.src1, IDX_W'($urandom), IDX_W'($urandom),
			1'($urandom), rand_word()));
		queue_instr(make_instr(K_IN, op.three ? op.src2 : op.dest, IDX_W'($urandom),
			IDX_W'($urandom), 1'($urandom), rand_word()));
		queue_instr(op);
		queue_instr(make_instr(K_OUT, op.dest, IDX_W'($urandom), IDX_W'($urandom),
			1'($urandom), rand_word()));
	endfunction

	function automatic int pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(21, 100);
	endfunction

	function automatic void report_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%s", msg);
	endfunction

	// Clock.
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Input driver: presents queued instructions with random gaps between beats.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				execute_instr(presented);
				beats_taken++;
				send_gap = calm ? 0 : pause_len();
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (instr_queue.size() > 0) begin
					presented = instr_queue.pop_front();
					in_valid <= 1'b1;
					kind <= presented.kind;
					dest_reg <= presented.dest;
					first_src <= presented.src1;
					second_src <= presented.src2;
					three_operand <= presented.three;
					immediate <= presented.imm;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each OUT beat and drives random stall patterns.
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (out_expected.size() == 0) begin
					report_failure($sformatf("unexpected result: out_value=%0d", out_value));
				end else begin
					want = out_expected.pop_front();
					if (out_value !== want)
						report_failure($sformatf("out_value mismatch: expected %0d, got %0d",
							$signed(want), out_value));
				end
			end
			// Two long hold-offs let the machine back up into its input.
			if ((holds_done == 0 && beats_taken >= 60) ||
					(holds_done == 1 && beats_taken >= 700)) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_gap = calm ? 0 : pause_len();
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("four_register_alu_machine_top_test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		for (int i = 0; i < NUM_REGS_DEF; i++)
			arch_regs[i] = '0;

		// Directed: reset contents, extremes, overflowing and zero divides, every kind.
		queue_instr(make_instr(K_OUT, 2'd0, 2'd3, 2'd3, 1'b1, WORD_ONES));
		queue_instr(make_instr(K_IN, 2'd0, 2'd0, 2'd0, 1'b0, WORD_MAX));
		queue_instr(make_instr(K_IN, 2'd1, 2'd3, 2'd3, 1'b1, WORD_MIN));
		queue_instr(make_instr(K_IN, 2'd2, 2'd0, 2'd0, 1'b0, WORD_ONES));
		queue_instr(make_instr(K_DIV, 2'd3, 2'd1, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_OUT, 2'd3, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_MOD, 2'd3, 2'd1, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_OUT, 2'd3, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_DIV, 2'd0, 2'd3, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_MOD, 2'd1, 2'd3, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_OUT, 2'd1, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_ADD, 2'd0, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_MUL, 2'd3, 2'd1, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_SUB, 2'd2, 2'd1, 2'd0, 1'b1, '0));
		queue_instr(make_instr(K_AND, 2'd2, 2'd1, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_OR, 2'd0, 2'd1, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_XOR, 2'd1, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_MOV, 2'd3, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_XCHG, 2'd0, 2'd1, 2'd0, 1'b0, '0));
		queue_instr(make_instr(KIND_LAST, 2'd3, 2'd3, 2'd3, 1'b1, WORD_ONES));
		queue_instr(make_instr(K_IN, 2'd3, 2'd0, 2'd0, 1'b0, -64'sd7));
		queue_instr(make_instr(K_IN, 2'd2, 2'd0, 2'd0, 1'b0, 64'sd2));
		queue_instr(make_instr(K_DIV, 2'd1, 2'd3, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_MOD, 2'd0, 2'd3, 2'd2, 1'b1, '0));
		queue_instr(make_instr(K_OUT, 2'd0, 2'd0, 2'd0, 1'b0, '0));
		queue_instr(make_instr(K_OUT, 2'd1, 2'd0, 2'd0, 1'b0, '0));

		// Random: mostly load-operate-read sequences, the rest loose instructions.
		useful_count = 0;
		while (useful_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 65)
				queue_alu_sequence();
			else
				queue_instr(rand_instr());
		end
		instr_total = instr_queue.size();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken < instr_total || out_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("four_register_alu_machine_top_test passed");
		else
			$display("four_register_alu_machine_top_test failed");
		$finish;
	end

endmodule
